[design/wanc_pkg.sv]
package wanc_pkg;

	localparam int CharW    = 21;
	localparam int LenW     = 3;
	localparam int NumPrefix = 7;
	localparam int NumSuffix = 11;
	localparam int PrefixW  = 3;
	localparam int SuffixW  = 4;

	localparam logic [LenW-1:0] LenSat = 3'd4;

	typedef logic [CharW-1:0] char_t;

	localparam char_t ChPlus    = 21'h00002B;
	localparam char_t ChMinus   = 21'h00002D;
	localparam char_t ChDot     = 21'h00002E;
	localparam char_t ChZero    = 21'h000030;
	localparam char_t ChNine    = 21'h000039;
	localparam char_t ChLowE    = 21'h000065;
	localparam char_t ChUpE     = 21'h000045;
	localparam char_t ChLowD    = 21'h000064;
	localparam char_t ChUpD     = 21'h000044;
	localparam char_t ChAsciiEnd = 21'h000080;

	localparam char_t ArabicDigitLo  = 21'h000660;
	localparam char_t ArabicDigitHi  = 21'h000669;
	localparam char_t ExtArabicLo    = 21'h0006F0;
	localparam char_t ExtArabicHi    = 21'h0006F9;
	localparam char_t DevanagariLo   = 21'h000966;
	localparam char_t DevanagariHi   = 21'h00096F;

	// Affix entry: length and up to three characters. Prefixes are stored from
	// the start of the word, suffixes from the end of the word backward.
	typedef struct packed {
		logic [1:0] len;
		char_t      ch2;
		char_t      ch1;
		char_t      ch0;
	} affix_t;

	localparam affix_t PrefixTab [NumPrefix] = '{
		'{2'd1, 21'h0, 21'h0,      21'h0623},
		'{2'd2, 21'h0, 21'h0644,   21'h0627},
		'{2'd1, 21'h0, 21'h0,      21'h0646},
		'{2'd1, 21'h0, 21'h0,      21'h0633},
		'{2'd1, 21'h0, 21'h0,      21'h062A},
		'{2'd1, 21'h0, 21'h0,      21'h064A},
		'{2'd1, 21'h0, 21'h0,      21'h0622}
	};

	localparam affix_t SuffixTab [NumSuffix] = '{
		'{2'd3, 21'h062A, 21'h064A, 21'h0646},
		'{2'd2, 21'h0,    21'h062A, 21'h064A},
		'{2'd2, 21'h0,    21'h064A, 21'h0646},
		'{2'd2, 21'h0,    21'h0648, 21'h0646},
		'{2'd2, 21'h0,    21'h0627, 21'h0646},
		'{2'd2, 21'h0,    21'h062A, 21'h0627},
		'{2'd2, 21'h0,    21'h0622, 21'h062A},
		'{2'd2, 21'h0,    21'h0627, 21'h062A},
		'{2'd1, 21'h0,    21'h0,    21'h0627},
		'{2'd1, 21'h0,    21'h0,    21'h0629},
		'{2'd1, 21'h0,    21'h0,    21'h062A}
	};

	function automatic logic is_wide_digit(input char_t c);
		return (c >= ArabicDigitLo && c <= ArabicDigitHi) ||
			(c >= ExtArabicLo && c <= ExtArabicHi) ||
			(c >= DevanagariLo && c <= DevanagariHi);
	endfunction

endpackage

[design/word_affix_number_classifier.sv]
// A character item is registered in the input stage on acceptance and processed there;
// a word's result is registered onto m_tvalid as its last character leaves that stage.
// Throughput: one character item per cycle, set by the single input register stage and
// the result register; a waiting result stalls only a following last character.
// Reset (arst_n low, asynchronous): word state cleared, reduced mode off, no result pending.
module word_affix_number_classifier import wanc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [20:0] char_code, [23:21] zero
	input  logic        s_tlast,   // last_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [2:0] prefix_class, [6:3] suffix_class, [7] is_number
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // reduced_mode
);

	logic                 valid_s1;
	char_t                char_s1;
	logic                 last_s1;
	logic                 adv_s1;

	logic                 reduced_q;
	logic [LenW-1:0]      len_q;
	char_t                first_q [2];
	char_t                recent_q [3];
	logic                 failed_q;
	logic                 digit_q;
	logic                 prev_digit_q;

	logic                 m_valid_q;
	logic [PrefixW-1:0]   prefix_q;
	logic [SuffixW-1:0]   suffix_q;
	logic                 number_q;

	logic [LenW-1:0]      len_nx;
	char_t                first_nx [2];
	char_t                recent_nx [3];
	logic                 failed_nx;
	logic                 digit_nx;
	logic                 ascii_digit;
	logic                 is_num;
	logic [PrefixW-1:0]   prefix_nx;
	logic [SuffixW-1:0]   suffix_nx;

	assign adv_s1    = valid_s1 && (!last_s1 || !m_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {number_q, suffix_q, prefix_q};

	always_comb begin
		logic ok;
		ascii_digit = (char_s1 >= ChZero) && (char_s1 <= ChNine);
		failed_nx   = failed_q;
		digit_nx    = digit_q;
		if (len_q == '0 && (char_s1 == ChPlus || char_s1 == ChMinus)) begin
			// A leading sign is allowed.
		end else if (char_s1 < ChAsciiEnd) begin
			if (ascii_digit) begin
				digit_nx = 1'b1;
			end else if (char_s1 == ChDot) begin
			end else if ((char_s1 == ChLowE || char_s1 == ChUpE) && prev_digit_q && !last_s1) begin
			end else if ((char_s1 == ChLowD || char_s1 == ChUpD) && last_s1) begin
			end else begin
				failed_nx = 1'b1;
			end
		end else if (is_wide_digit(char_s1)) begin
			digit_nx = 1'b1;
		end else begin
			failed_nx = 1'b1;
		end

		first_nx[0]  = (len_q == 3'd0) ? char_s1 : first_q[0];
		first_nx[1]  = (len_q == 3'd1) ? char_s1 : first_q[1];
		recent_nx[0] = char_s1;
		recent_nx[1] = recent_q[0];
		recent_nx[2] = recent_q[1];
		len_nx       = (len_q < LenSat) ? len_q + 3'd1 : len_q;

		is_num = !failed_nx && digit_nx;

		// Walk the tables from the lowest priority up so the first match wins.
		prefix_nx = '0;
		for (int i = NumPrefix - 1; i >= 0; i--) begin
			ok = len_nx > {1'b0, PrefixTab[i].len};
			if (first_nx[0] != PrefixTab[i].ch0) ok = 1'b0;
			if (PrefixTab[i].len > 2'd1 && first_nx[1] != PrefixTab[i].ch1) ok = 1'b0;
			if (ok) prefix_nx = PrefixW'(i + 1);
		end

		suffix_nx = '0;
		for (int i = NumSuffix - 1; i >= 0; i--) begin
			ok = len_nx > {1'b0, SuffixTab[i].len};
			if (recent_nx[0] != SuffixTab[i].ch0) ok = 1'b0;
			if (SuffixTab[i].len > 2'd1 && recent_nx[1] != SuffixTab[i].ch1) ok = 1'b0;
			if (SuffixTab[i].len > 2'd2 && recent_nx[2] != SuffixTab[i].ch2) ok = 1'b0;
			if (ok) suffix_nx = SuffixW'(i + 1);
		end

		if (is_num || reduced_q) begin
			prefix_nx = '0;
			suffix_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			reduced_q    <= 1'b0;
			len_q        <= '0;
			first_q      <= '{default: '0};
			recent_q     <= '{default: '0};
			failed_q     <= 1'b0;
			digit_q      <= 1'b0;
			prev_digit_q <= 1'b0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) reduced_q <= cfg_data;
			if (s_tready) valid_s1 <= s_tvalid;

			if (adv_s1) begin
				if (last_s1) begin
					len_q        <= '0;
					first_q      <= '{default: '0};
					recent_q     <= '{default: '0};
					failed_q     <= 1'b0;
					digit_q      <= 1'b0;
					prev_digit_q <= 1'b0;
				end else begin
					len_q        <= len_nx;
					first_q      <= first_nx;
					recent_q     <= recent_nx;
					failed_q     <= failed_nx;
					digit_q      <= digit_nx;
					prev_digit_q <= ascii_digit;
				end
			end

			if (adv_s1 && last_s1) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata[CharW-1:0];
			last_s1 <= s_tlast;
		end
		if (adv_s1 && last_s1) begin
			prefix_q <= prefix_nx;
			suffix_q <= suffix_nx;
			number_q <= is_num;
		end
	end

	a_num_no_class: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && number_q) |-> (prefix_q == '0 && suffix_q == '0))
		else $error("number result carries an affix class");

	a_suffix_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (suffix_q <= SuffixW'(NumSuffix)))
		else $error("suffix class out of range");

	a_len_sat: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LenSat)
		else $error("length counter beyond saturation");

	a_word_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (len_q == '0 && m_valid_q))
		else $error("word end did not clear state or post a result");

endmodule
